### sv/roct_pkg.sv
package roct_pkg;

    localparam int COORD_W       = 24;
    localparam int ID_W          = 20;
    localparam int OP_W          = 2;
    localparam int DEFAULT_DEPTH = 64;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR        = 2'd0,
        OP_INSERT       = 2'd1,
        OP_QUERY        = 2'd2,
        OP_QUERY_INSERT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_low;
        logic signed [COORD_W-1:0] y_low;
        logic signed [COORD_W-1:0] x_high;
        logic signed [COORD_W-1:0] y_high;
        logic        [ID_W-1:0]    entry_id;
    } entry_t;

endpackage

### sv/roct_mem.sv
module roct_mem #(
    parameter int TABLE_DEPTH = roct_pkg::DEFAULT_DEPTH,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output roct_pkg::entry_t rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  roct_pkg::entry_t wr_data
);

    roct_pkg::entry_t mem [TABLE_DEPTH];
    roct_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/roct_ctrl.sv
module roct_ctrl #(
    parameter int TABLE_DEPTH = roct_pkg::DEFAULT_DEPTH,
    parameter int AW          = $clog2(TABLE_DEPTH),
    parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [roct_pkg::OP_W-1:0]            opcode,
    input  logic signed [roct_pkg::COORD_W-1:0]  x_low,
    input  logic signed [roct_pkg::COORD_W-1:0]  y_low,
    input  logic signed [roct_pkg::COORD_W-1:0]  x_high,
    input  logic signed [roct_pkg::COORD_W-1:0]  y_high,
    input  logic [roct_pkg::ID_W-1:0]            entry_id,
    output logic                                 rd_en,
    output logic [AW-1:0]                        rd_addr,
    input  roct_pkg::entry_t                     rd_data,
    output logic                                 wr_en,
    output logic [AW-1:0]                        wr_addr,
    output roct_pkg::entry_t                     wr_data,
    output logic                                 done,
    output logic                                 conflicted,
    output logic                                 inserted,
    output logic                                 table_full
);

    roct_pkg::state_t state_reg, state_next;
    roct_pkg::op_t    op_reg, op_next;
    roct_pkg::entry_t req_reg, req_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic             rd_valid_reg;
    logic             conf_reg, conf_next;
    logic             done_reg, done_next;
    logic             conflicted_reg, conflicted_next;
    logic             inserted_reg, inserted_next;
    logic             full_reg, full_next;

    logic accept;
    logic hit;
    logic last_idx;
    logic do_insert;
    logic is_full;

    assign accept = start && (state_reg == roct_pkg::ST_IDLE);
    assign busy   = (state_reg != roct_pkg::ST_IDLE);

    // inclusive overlap, entries carrying the query's own id are skipped
    assign hit = rd_valid_reg
              && (rd_data.entry_id != req_reg.entry_id)
              && ($signed(rd_data.x_low) <= $signed(req_reg.x_high))
              && ($signed(req_reg.x_low) <= $signed(rd_data.x_high))
              && ($signed(rd_data.y_low) <= $signed(req_reg.y_high))
              && ($signed(req_reg.y_low) <= $signed(rd_data.y_high));

    assign last_idx  = ({{(CW-AW){1'b0}}, idx_reg} == (count_reg - CW'(1)));
    assign is_full   = (count_reg == CW'(TABLE_DEPTH));
    assign do_insert = (op_reg == roct_pkg::OP_INSERT)
                    || ((op_reg == roct_pkg::OP_QUERY_INSERT) && !conf_reg);

    assign rd_addr = idx_reg;
    assign wr_addr = count_reg[AW-1:0];
    assign wr_data = req_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        req_next        = req_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        conf_next       = conf_reg;
        done_next       = 1'b0;
        conflicted_next = 1'b0;
        inserted_next   = 1'b0;
        full_next       = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;

        case (state_reg)
            roct_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = roct_pkg::op_t'(opcode);
                    req_next  = '{x_low: x_low, y_low: y_low, x_high: x_high,
                                  y_high: y_high, entry_id: entry_id};
                    idx_next  = '0;
                    conf_next = 1'b0;
                    if ((opcode inside {roct_pkg::OP_QUERY, roct_pkg::OP_QUERY_INSERT})
                        && (count_reg != '0))
                    begin
                        state_next = roct_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = roct_pkg::ST_FINISH;
                    end
                end
            end
            roct_pkg::ST_SCAN:
            begin
                rd_en = 1'b1;
                if (hit)
                begin
                    // early exit, reads still in flight are dropped
                    conf_next  = 1'b1;
                    rd_en      = 1'b0;
                    state_next = roct_pkg::ST_FINISH;
                end
                else if (last_idx)
                begin
                    state_next = roct_pkg::ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            roct_pkg::ST_DRAIN:
            begin
                conf_next  = hit;
                state_next = roct_pkg::ST_FINISH;
            end
            roct_pkg::ST_FINISH:
            begin
                done_next       = 1'b1;
                conflicted_next = conf_reg;
                if (op_reg == roct_pkg::OP_CLEAR)
                begin
                    count_next = '0;
                end
                else if (do_insert)
                begin
                    if (is_full)
                    begin
                        full_next = 1'b1;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        inserted_next = 1'b1;
                        count_next    = count_reg + CW'(1);
                    end
                end
                state_next = roct_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = roct_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= roct_pkg::ST_IDLE;
            op_reg         <= roct_pkg::OP_CLEAR;
            count_reg      <= '0;
            idx_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            conf_reg       <= 1'b0;
            done_reg       <= 1'b0;
            conflicted_reg <= 1'b0;
            inserted_reg   <= 1'b0;
            full_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            rd_valid_reg   <= rd_en;
            conf_reg       <= conf_next;
            done_reg       <= done_next;
            conflicted_reg <= conflicted_next;
            inserted_reg   <= inserted_next;
            full_reg       <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

    assign done       = done_reg;
    assign conflicted = conflicted_reg;
    assign inserted   = inserted_reg;
    assign table_full = full_reg;

endmodule

### sv/rect_overlap_conflict_table.sv
// Rectangle overlap table for greedy batching of non-overlapping windows.
// Command channel: drive opcode, the rectangle edges and entry_id with start high;
// the beat is taken at a rising edge where start is high and busy is low.
// Opcodes: clear, insert, query, query then insert if no conflict.
// Result channel: done pulses for one cycle with conflicted, inserted and
// table_full; the receiver must take the beat in that cycle.
// Overlap is inclusive (touching edges conflict); stored entries with the
// same entry_id as the command are ignored.
// Sequence: clear, insert and a query on an empty table go from accept to the
// finish state, then done. Any other query reads the stored entries one per
// cycle from a single-port-read memory, then drains the last read; a conflict
// ends the scan early. busy drops in the cycle done is shown, so the next
// command may be taken then.
// The table write happens at the last busy cycle, before any later read,
// so no forwarding is needed.
// Reset empties the table at once (entry count to zero); no clearing pass.
module rect_overlap_conflict_table #(
    parameter int TABLE_DEPTH = roct_pkg::DEFAULT_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [roct_pkg::OP_W-1:0]           opcode,
    input  logic signed [roct_pkg::COORD_W-1:0] x_low,
    input  logic signed [roct_pkg::COORD_W-1:0] y_low,
    input  logic signed [roct_pkg::COORD_W-1:0] x_high,
    input  logic signed [roct_pkg::COORD_W-1:0] y_high,
    input  logic [roct_pkg::ID_W-1:0]           entry_id,
    output logic                                done,
    output logic                                conflicted,
    output logic                                inserted,
    output logic                                table_full
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    roct_pkg::entry_t rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    roct_pkg::entry_t wr_data;

    roct_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    roct_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .x_low      (x_low),
        .y_low      (y_low),
        .x_high     (x_high),
        .y_high     (y_high),
        .entry_id   (entry_id),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .done       (done),
        .conflicted (conflicted),
        .inserted   (inserted),
        .table_full (table_full)
    );

endmodule

### sv/roct_checker.sv
module roct_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic conflicted,
    input logic inserted,
    input logic table_full
);

    // a refused insert never also reports a stored entry
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(inserted && table_full))
        else $error("inserted and table_full together");

    // a conflict always blocks the store
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(conflicted && inserted))
        else $error("conflicted beat also inserted");

    // an accepted command keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted command did not start work");

    // every result beat closes a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result beat without a preceding busy cycle");

endmodule

bind rect_overlap_conflict_table roct_checker u_roct_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .conflicted (conflicted),
    .inserted   (inserted),
    .table_full (table_full)
);

### tb/rect_overlap_conflict_table_tb.sv
module rect_overlap_conflict_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH  = roct_pkg::DEFAULT_DEPTH;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int LATENCY_TAIL = TABLE_DEPTH + 8;
    localparam int RANDOM_ITEMS = 1500;

    typedef logic signed [roct_pkg::COORD_W-1:0] coord_t;
    typedef logic [roct_pkg::ID_W-1:0]           rect_id_t;

    typedef struct packed {
        logic conflicted;
        logic inserted;
        logic table_full;
    } outcome_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [roct_pkg::OP_W-1:0] opcode;
    coord_t                    x_low;
    coord_t                    y_low;
    coord_t                    x_high;
    coord_t                    y_high;
    rect_id_t                  entry_id;
    logic                      done;
    logic                      conflicted;
    logic                      inserted;
    logic                      table_full;

    // shadow copy of the stored rectangles
    coord_t             rect_lefts   [TABLE_DEPTH];
    coord_t             rect_bottoms [TABLE_DEPTH];
    coord_t             rect_rights  [TABLE_DEPTH];
    coord_t             rect_tops    [TABLE_DEPTH];
    rect_id_t           rect_ids     [TABLE_DEPTH];
    int                 rect_count;

    outcome_t           pending_outcomes[$];
    outcome_t           seen_outcome;
    outcome_t           wanted_outcome;
    int                 mismatch_count;
    int                 issued_count;
    int                 cycle_count;
    bit                 no_idle;

    rect_overlap_conflict_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .x_low      (x_low),
        .y_low      (y_low),
        .x_high     (x_high),
        .y_high     (y_high),
        .entry_id   (entry_id),
        .done       (done),
        .conflicted (conflicted),
        .inserted   (inserted),
        .table_full (table_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic outcome_t apply_command(input roct_pkg::op_t op, input coord_t xl,
                                               input coord_t yl, input coord_t xh,
                                               input coord_t yh, input rect_id_t id);
        outcome_t res;
        res = '0;
        if (op == roct_pkg::OP_CLEAR)
        begin
            rect_count = 0;
        end
        else
        begin
            if (op == roct_pkg::OP_QUERY || op == roct_pkg::OP_QUERY_INSERT)
            begin
                for (int i = 0; i < rect_count; i++)
                begin
                    if (rect_ids[i] != id && rect_lefts[i] <= xh && xl <= rect_rights[i]
                        && rect_bottoms[i] <= yh && yl <= rect_tops[i])
                        res.conflicted = 1'b1;
                end
            end
            if (op == roct_pkg::OP_INSERT
                || (op == roct_pkg::OP_QUERY_INSERT && !res.conflicted))
            begin
                if (rect_count < TABLE_DEPTH)
                begin
                    rect_lefts[rect_count]   = xl;
                    rect_bottoms[rect_count] = yl;
                    rect_rights[rect_count]  = xh;
                    rect_tops[rect_count]    = yh;
                    rect_ids[rect_count]     = id;
                    rect_count++;
                    res.inserted = 1'b1;
                end
                else
                begin
                    res.table_full = 1'b1;
                end
            end
        end
        return res;
    endfunction

    task automatic note_failure(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", what);
    endtask

    // one command beat; start stays high afterwards unless the next call idles
    task automatic issue_command(input roct_pkg::op_t op, input coord_t xl, input coord_t yl,
                                 input coord_t xh, input coord_t yh, input rect_id_t id);
        int gap;
        if (!no_idle && $urandom_range(0, 99) < 37)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 80)
                                              : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        opcode   <= op;
        x_low    <= xl;
        y_low    <= yl;
        x_high   <= xh;
        y_high   <= yh;
        entry_id <= id;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_outcomes = {pending_outcomes, apply_command(op, xl, yl, xh, yh, id)};
        issued_count++;
    endtask

    task automatic issue_rect(input roct_pkg::op_t op, input int xl, input int yl,
                              input int xh, input int yh, input rect_id_t id);
        issue_command(op, coord_t'(xl), coord_t'(yl), coord_t'(xh), coord_t'(yh), id);
    endtask

    task automatic issue_random_rect(input roct_pkg::op_t op, input int span,
                                     input coord_t base);
        coord_t   xl;
        coord_t   yl;
        coord_t   xh;
        coord_t   yh;
        coord_t   swap;
        rect_id_t id;
        if ($urandom_range(0, 99) < 12)
        begin
            xl = coord_t'($urandom);
            yl = coord_t'($urandom);
            xh = coord_t'($urandom);
            yh = coord_t'($urandom);
            id = rect_id_t'($urandom);
        end
        else
        begin
            xl = base + coord_t'($urandom_range(0, span));
            yl = base + coord_t'($urandom_range(0, span));
            xh = xl + coord_t'($urandom_range(0, 40));
            yh = yl + coord_t'($urandom_range(0, 40));
            id = rect_id_t'($urandom_range(0, 15));
            if ($urandom_range(0, 15) == 0)
            begin
                swap = xl;
                xl   = xh;
                xh   = swap;
            end
        end
        issue_command(op, xl, yl, xh, yh, id);
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_cases();
        int lo;
        int hi;
        lo = -8388608;
        hi = 8388607;
        issue_rect(roct_pkg::OP_QUERY, 0, 0, 10, 10, 20'd2);
        issue_rect(roct_pkg::OP_INSERT, 0, 0, 10, 10, 20'd1);
        // corner and edge contact count as overlap
        issue_rect(roct_pkg::OP_QUERY, 10, 10, 20, 20, 20'd2);
        issue_rect(roct_pkg::OP_QUERY, -5, 10, 0, 15, 20'd2);
        issue_rect(roct_pkg::OP_QUERY, 11, 0, 20, 10, 20'd2);
        issue_rect(roct_pkg::OP_QUERY, 0, 11, 10, 20, 20'd2);
        // same id never conflicts with itself
        issue_rect(roct_pkg::OP_QUERY, 0, 0, 10, 10, 20'd1);
        issue_rect(roct_pkg::OP_QUERY_INSERT, 11, 11, 20, 20, 20'd2);
        issue_rect(roct_pkg::OP_QUERY_INSERT, 5, 5, 6, 6, 20'd3);
        issue_rect(roct_pkg::OP_INSERT, 5, 5, 6, 6, 20'd3);
        // inverted rectangles are compared as given
        issue_rect(roct_pkg::OP_INSERT, 30, 30, 25, 25, 20'd4);
        issue_rect(roct_pkg::OP_QUERY, 26, 26, 27, 27, 20'd5);
        issue_rect(roct_pkg::OP_QUERY, 25, 25, 30, 30, 20'd5);
        issue_rect(roct_pkg::OP_QUERY, 20, 0, 0, 10, 20'd9);
        issue_rect(roct_pkg::OP_INSERT, lo, lo, lo, lo, 20'hFFFFF);
        issue_rect(roct_pkg::OP_INSERT, hi, hi, hi, hi, 20'd0);
        issue_rect(roct_pkg::OP_QUERY, hi, hi, hi, hi, 20'hFFFFF);
        issue_rect(roct_pkg::OP_QUERY, lo, lo, hi, hi, 20'd0);
        issue_rect(roct_pkg::OP_QUERY_INSERT, lo, lo, lo, lo, 20'd5);
        issue_rect(roct_pkg::OP_CLEAR, 5592405, -5592406, hi, lo, 20'hFFFFF);
        issue_rect(roct_pkg::OP_QUERY, lo, lo, hi, hi, 20'd0);
        issue_rect(roct_pkg::OP_QUERY_INSERT, lo, lo, hi, hi, 20'd0);
        issue_rect(roct_pkg::OP_QUERY_INSERT, 0, 0, 0, 0, 20'hAAAAA);
    endtask

    task automatic test_table_full();
        int lo;
        lo = -8388608;
        issue_rect(roct_pkg::OP_CLEAR, 0, 0, 0, 0, 20'd0);
        repeat (TABLE_DEPTH)
            issue_random_rect(roct_pkg::OP_INSERT, 1000, '0);
        issue_rect(roct_pkg::OP_INSERT, 0, 0, 1, 1, 20'd7);
        // far corner: full scan with no hit, then refused for lack of room
        issue_rect(roct_pkg::OP_QUERY, lo, lo, lo + 8, lo + 8, 20'h12345);
        issue_rect(roct_pkg::OP_QUERY_INSERT, lo, lo, lo + 8, lo + 8, 20'h12345);
        issue_rect(roct_pkg::OP_QUERY_INSERT, -100, -100, 1200, 1200, 20'hABCDE);
        issue_rect(roct_pkg::OP_QUERY, -100, -100, 1200, 1200, 20'hABCDE);
        issue_rect(roct_pkg::OP_CLEAR, 0, 0, 0, 0, 20'd0);
        issue_rect(roct_pkg::OP_INSERT, 0, 0, 1, 1, 20'd7);
    endtask

    task automatic test_random_batches();
        int            batch;
        int            len;
        int            pick;
        int            span;
        int            stop_at;
        coord_t        base;
        roct_pkg::op_t op;
        batch   = 0;
        stop_at = issued_count + RANDOM_ITEMS;
        while (issued_count < stop_at)
        begin
            no_idle = (batch >= 4 && batch < 9);
            span    = $urandom_range(30, 1000);
            base    = ($urandom_range(0, 3) == 0) ? coord_t'($urandom) : coord_t'(-span / 2);
            issue_random_rect(roct_pkg::OP_CLEAR, span, base);
            len = $urandom_range(1, 90);
            repeat (len)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    op = roct_pkg::OP_QUERY_INSERT;
                else if (pick < 82)
                    op = roct_pkg::OP_INSERT;
                else if (pick < 95)
                    op = roct_pkg::OP_QUERY;
                else
                    op = roct_pkg::OP_CLEAR;
                issue_random_rect(op, span, base);
            end
            batch++;
        end
        no_idle = 1'b0;
    endtask

    task automatic test_pause_until_drained();
        repeat (3)
        begin
            repeat ($urandom_range(2, 20))
                issue_random_rect(roct_pkg::OP_QUERY_INSERT, 200, '0);
            hold_until_drained();
            issue_random_rect(roct_pkg::OP_QUERY, 200, '0);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            seen_outcome = '{conflicted, inserted, table_full};
            if (pending_outcomes.size() == 0)
            begin
                note_failure($sformatf(
                    "unexpected result beat: conflicted=%0b inserted=%0b table_full=%0b",
                    conflicted, inserted, table_full));
            end
            else
            begin
                wanted_outcome = pending_outcomes.pop_front();
                if (seen_outcome !== wanted_outcome)
                    note_failure($sformatf(
                        "mismatch: conflicted %0b/%0b inserted %0b/%0b table_full %0b/%0b (exp/got)",
                        wanted_outcome.conflicted, seen_outcome.conflicted,
                        wanted_outcome.inserted, seen_outcome.inserted,
                        wanted_outcome.table_full, seen_outcome.table_full));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("rect_overlap_conflict_table_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        start          <= 1'b0;
        opcode         <= roct_pkg::OP_CLEAR;
        x_low          <= '0;
        y_low          <= '0;
        x_high         <= '0;
        y_high         <= '0;
        entry_id       <= '0;
        rect_count     = 0;
        mismatch_count = 0;
        issued_count   = 0;
        no_idle        = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_table_full();
        test_random_batches();
        test_pause_until_drained();

        hold_until_drained();
        repeat (LATENCY_TAIL) @(posedge clk);
        if (pending_outcomes.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_outcomes.size()));
        if (mismatch_count == 0)
            $display("rect_overlap_conflict_table_tb: done, clean");
        else
            $display("rect_overlap_conflict_table_tb: done, errors");
        $finish;
    end

endmodule
